@@ rtl/core/indexed_list_engine_assert.svh @@
// Assertion macros for the indexed list engine, included by the request sequencer.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ILE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ILE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ILE_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define ILE_ASSERT(lbl, clk, rstn, prop, msg)
`define ILE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/core/ile_pkg.sv @@
// Types and constants for the indexed list engine.
package ile_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned POS_W   = 7;

  typedef enum logic [2:0] {
    ACT_READ     = 3'd0,
    ACT_INS_HEAD = 3'd1,
    ACT_INS_TAIL = 3'd2,
    ACT_INS_POS  = 3'd3,
    ACT_DELETE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [COUNT_W-1:0]       entry_count;
    status_e                  status;
    logic signed [DATA_W-1:0] read_value;
  } res_t;

endpackage

@@ rtl/core/ile_ram.sv @@
// Single write port, single registered read port list storage.
module ile_ram import ile_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/ile_ctrl.sv @@
// Request sequencer: decodes a request and walks the shift one entry per cycle.
module ile_ctrl import ile_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  action_e           in_action_i,
  input  logic [POS_W-1:0]  in_position_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  `include "indexed_list_engine_assert.svh"

  typedef enum logic [2:0] {
    StIdle,
    StRdWait,
    StShift,
    StWrite,
    StFinish
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              ins_q, ins_d;
  logic [DATA_W-1:0] val_q, val_d;
  res_t              res_q, res_d;

  logic [POS_W-1:0]  cnt_ext;
  logic              full;
  logic [AW-1:0]     tgt;
  logic [AW-1:0]     step;
  logic [AW-1:0]     ahead;
  logic              last_move;

  assign cnt_ext = POS_W'(count_q);
  assign full    = (count_q == CW'(CAPACITY));

  // Shared pointer unit: one place toward the gap, and the read one beyond it.
  assign step      = ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
  assign ahead     = ins_q ? step - AW'(1) : step + AW'(1);
  assign last_move = ins_q ? (step == pos_q) : (step == count_q[AW-1:0]);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    ins_d       = ins_q;
    val_d       = val_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ahead;
    tgt         = in_position_i[AW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_d.read_value = '0;
          res_d.status     = ST_DONE;
          state_d          = StFinish;
          unique case (in_action_i)
            ACT_READ: begin
              if (in_position_i >= cnt_ext) begin
                res_d.read_value = '1;
                res_d.status     = ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = in_position_i[AW-1:0];
                state_d     = StRdWait;
              end
            end
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
              if (in_action_i == ACT_INS_HEAD) begin
                tgt = '0;
              end else if (in_action_i == ACT_INS_TAIL) begin
                tgt = count_q[AW-1:0];
              end
              if (in_action_i == ACT_INS_POS && in_position_i > cnt_ext) begin
                res_d.status = ST_RANGE;
              end else if (full) begin
                res_d.status = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                pos_d   = tgt;
                val_d   = in_value_i;
                ins_d   = 1'b1;
                if (tgt == count_q[AW-1:0]) begin
                  // Append at the end: nothing to move.
                  mem_we_o    = 1'b1;
                  mem_waddr_o = tgt;
                  mem_wdata_o = in_value_i;
                end else begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = count_q[AW-1:0] - AW'(1);
                  ptr_d       = count_q[AW-1:0];
                  state_d     = StShift;
                end
              end
            end
            ACT_DELETE: begin
              if (in_position_i >= cnt_ext) begin
                res_d.status = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                ins_d   = 1'b0;
                if (in_position_i != cnt_ext - POS_W'(1)) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = in_position_i[AW-1:0] + AW'(1);
                  ptr_d       = in_position_i[AW-1:0];
                  state_d     = StShift;
                end
              end
            end
            default: ;
          endcase
          res_d.entry_count = COUNT_W'(count_d);
        end
      end
      StRdWait: begin
        res_d.read_value = mem_rdata_i;
        state_d          = StFinish;
      end
      StShift: begin
        mem_we_o = 1'b1;
        if (last_move) begin
          state_d = ins_q ? StWrite : StFinish;
        end else begin
          mem_re_o = 1'b1;
          ptr_d    = step;
        end
      end
      StWrite: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        state_d     = StFinish;
      end
      StFinish: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      pos_q   <= '0;
      ptr_q   <= '0;
      ins_q   <= 1'b0;
      val_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      ptr_q   <= ptr_d;
      ins_q   <= ins_d;
      val_q   <= val_d;
      res_q   <= res_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StFinish);
  assign res_o       = res_q;

  `ILE_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count above capacity")
  `ILE_ASSERT(a_count_on_accept, clk_i, rst_ni, !$stable(count_q) |-> $past(in_valid_i && in_ready_o), "count changed outside accept")
  `ILE_ASSERT_NEVER(a_ptr_in_list, clk_i, rst_ni, state_q == StShift && CW'(ptr_q) >= count_q, "shift pointer past list end")

endmodule

@@ rtl/core/indexed_list_engine.sv @@
// Indexed list engine: ordered list of signed words with read, insert and delete by position.
//
// Keeps up to CAPACITY (2 to 64) signed 32-bit entries in one single-ported-write,
// registered-read memory. One request is in work at a time; s_axis_tready_o is low
// from acceptance until the result is handed to the output register, which may still
// hold the previous result while the next request runs. A read waits on the registered
// memory read before its result; a rejected or no-op request, an append and a delete of
// the last entry move no entries. An insert at position p moves every entry from p on,
// and a delete at position p every entry after p, one place per cycle through the
// memory's single write port; an insert then writes the new value into the gap at p.
// No clearing pass follows reset; entries are only read after they have been written.
module indexed_list_engine import ile_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] action, [9:3] position, [41:10] value, [47:42] zero
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_value, [33:32] status, [40:34] entry_count, [47:41] zero
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_q;
  res_t              out_q;

  ile_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_action_i  (action_e'(s_axis_tdata_i[2:0])),
    .in_position_i(s_axis_tdata_i[9:3]),
    .in_value_i   (s_axis_tdata_i[41:10]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ile_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Take a new result when the output slot is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.entry_count, out_q.status, out_q.read_value};

endmodule
